### sv/rwsp_pkg.sv
// Package for the RIFF/WAVE stream parser.
// It holds the phase enum, the result struct and the tag and format constants.
// It depends on nothing else.
package rwsp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;
	localparam logic [15:0] FMT_PCM  = 16'h0001;
	localparam logic [15:0] FMT_FLT  = 16'h0003;

	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_BADHDR  = 4'd1,
		PH_ID      = 4'd2,
		PH_SIZE    = 4'd3,
		PH_FMT     = 4'd4,
		PH_SKIP    = 4'd5,
		PH_PAD     = 4'd6,
		PH_SAMPLES = 4'd7,
		PH_IDLE    = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_HEADER    = 3'd1,
		ERR_SHORT     = 3'd2,
		ERR_FORMAT    = 3'd3,
		ERR_FLT_DEPTH = 3'd4
	} err_t;

	// One result item as it leaves the parser.
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] sample_value;
		logic [15:0]        channel_index;
		logic               frame_last;
		logic [2:0]         error_code;
		logic [31:0]        rate_out;
		logic [15:0]        channels_out;
		logic [15:0]        depth_out;
		logic               is_float;
	} res_t;

endpackage

### sv/rwsp_core.sv
// Core: one byte per cycle when fired steps the chunk walker, builds a result.
// Depends on rwsp_pkg.
module rwsp_core
	import rwsp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       res_valid,
	output res_t       res
);

	phase_t      phase_q, phase_d;
	logic [4:0]  fcnt_q, fcnt_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] clen_q, clen_d;
	logic [31:0] left_q, left_d;
	logic        seen_q, seen_d;
	logic [15:0] fid_q, fid_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] blk_q, blk_d;
	logic [15:0] bps_q, bps_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  sbi_q, sbi_d;
	logic [15:0] cur_q, cur_d;

	logic [31:0] tag_sh, len_sh, acc_new, val, rem_next;
	logic [2:0]  nb, sbi_inc;
	logic [16:0] cur_inc;
	logic        fl;

	assign tag_sh   = {in_byte, tag_q[31:8]};
	assign len_sh   = {in_byte, clen_q[31:8]};
	assign nb       = bps_q[5:3];
	assign sbi_inc  = sbi_q + 3'd1;
	assign acc_new  = acc_q | ({24'd0, in_byte} << {sbi_q[1:0], 3'b000});
	assign cur_inc  = {1'b0, cur_q} + 17'd1;
	assign fl       = (cur_inc >= {1'b0, chan_q});
	assign rem_next = left_q - {16'd0, blk_q};

	// Sign extension of a completed PCM sample.
	always_comb begin
		val = acc_new;
		if (fid_q != FMT_FLT) begin
			unique case (nb)
				3'd1: val = {{24{acc_new[7]}}, acc_new[7:0]};
				3'd2: val = {{16{acc_new[15]}}, acc_new[15:0]};
				3'd3: val = {{8{acc_new[23]}}, acc_new[23:0]};
				default: val = acc_new;
			endcase
		end
	end

	// Next state and result for the byte at the input.
	always_comb begin
		phase_d = phase_q; fcnt_d = fcnt_q; tag_d = tag_q; clen_d = clen_q;
		left_d = left_q; seen_d = seen_q; fid_d = fid_q; chan_d = chan_q;
		rate_d = rate_q; blk_d = blk_q; bps_d = bps_q; acc_d = acc_q;
		sbi_d = sbi_q; cur_d = cur_q;
		res_valid = 1'b0;
		res = '0;
		if (in_last && (phase_q < PH_SAMPLES)) begin
			res_valid = 1'b1;
			res.kind = KIND_ERROR;
			res.error_code = ERR_SHORT;
		end else begin
			unique case (phase_q)
				PH_HDR, PH_BADHDR: begin
					tag_d = tag_sh;
					if (fcnt_q == 5'd3 && tag_sh != TAG_RIFF) phase_d = PH_BADHDR;
					if (fcnt_q == 5'd11) begin
						if (phase_q == PH_BADHDR || tag_sh != TAG_WAVE) begin
							phase_d = PH_IDLE;
							res_valid = 1'b1;
							res.kind = KIND_ERROR;
							res.error_code = ERR_HEADER;
						end else begin
							phase_d = PH_ID;
							fcnt_d = '0;
						end
					end else begin
						fcnt_d = fcnt_q + 5'd1;
					end
				end
				PH_ID: begin
					tag_d = tag_sh;
					if (fcnt_q >= 5'd3) begin
						phase_d = PH_SIZE;
						fcnt_d = '0;
					end else begin
						fcnt_d = fcnt_q + 5'd1;
					end
				end
				PH_SIZE: begin
					clen_d = len_sh;
					fcnt_d = fcnt_q + 5'd1;
					if (fcnt_q >= 5'd3) begin
						fcnt_d = '0;
						left_d = len_sh;
						if (tag_q == TAG_FMT) begin
							seen_d = 1'b1;
							fid_d = '0; chan_d = '0; rate_d = '0; blk_d = '0; bps_d = '0;
							phase_d = (len_sh == '0) ? PH_ID : PH_FMT;
						end else if (tag_q == TAG_DATA && seen_q) begin
							res_valid = 1'b1;
							res.kind = KIND_ERROR;
							phase_d = PH_IDLE;
							if (fid_q != FMT_PCM && fid_q != FMT_FLT) begin
								res.error_code = ERR_FORMAT;
							end else if (fid_q == FMT_FLT && bps_q != 16'd32) begin
								res.error_code = ERR_FLT_DEPTH;
							end else if (fid_q == FMT_PCM && (bps_q == '0 ||
									bps_q[2:0] != 3'd0 || bps_q > 16'd32)) begin
								res.error_code = ERR_FORMAT;
							end else if (chan_q == '0 || blk_q == '0) begin
								res.error_code = ERR_FORMAT;
							end else begin
								// Left holds the bytes still owed to frames.
								res.kind = KIND_DONE;
								res.rate_out = rate_q;
								res.channels_out = chan_q;
								res.depth_out = bps_q;
								res.is_float = (fid_q == FMT_FLT);
								cur_d = '0; acc_d = '0; sbi_d = '0;
								phase_d = (len_sh >= {16'd0, blk_q}) ? PH_SAMPLES : PH_IDLE;
							end
						end else begin
							phase_d = (len_sh == '0) ? PH_ID : PH_SKIP;
						end
					end
				end
				PH_FMT, PH_SKIP: begin
					if (phase_q == PH_FMT && fcnt_q < 5'd16) begin
						fcnt_d = fcnt_q + 5'd1;
						unique case (fcnt_q[3:1])
							3'd0: if (fcnt_q[0]) fid_d[15:8] = in_byte;
								else fid_d[7:0] = in_byte;
							3'd1: if (fcnt_q[0]) chan_d[15:8] = in_byte;
								else chan_d[7:0] = in_byte;
							3'd2, 3'd3: rate_d[{fcnt_q[1:0], 3'b000} +: 8] = in_byte;
							3'd6: if (fcnt_q[0]) blk_d[15:8] = in_byte;
								else blk_d[7:0] = in_byte;
							3'd7: if (fcnt_q[0]) bps_d[15:8] = in_byte;
								else bps_d[7:0] = in_byte;
							default: ;
						endcase
					end
					left_d = left_q - 32'd1;
					if (left_q == 32'd1) begin
						phase_d = clen_q[0] ? PH_PAD : PH_ID;
						fcnt_d = '0;
					end
				end
				PH_PAD: begin
					phase_d = PH_ID;
					fcnt_d = '0;
				end
				PH_SAMPLES: begin
					if (nb == 3'd0 || nb > 3'd4) begin
						phase_d = PH_IDLE;
					end else if (sbi_inc < nb) begin
						acc_d = acc_new;
						sbi_d = sbi_inc;
					end else begin
						res_valid = 1'b1;
						res.kind = KIND_SAMPLE;
						res.sample_value = val;
						res.channel_index = cur_q;
						res.frame_last = fl;
						acc_d = '0;
						sbi_d = '0;
						if (fl) begin
							cur_d = '0;
							left_d = rem_next;
							if (rem_next < {16'd0, blk_q}) phase_d = PH_IDLE;
						end else begin
							cur_d = cur_inc[15:0];
						end
					end
				end
				default: ;
			endcase
		end
		// The flagged last byte returns everything to the reset state.
		if (in_last) begin
			phase_d = PH_HDR; fcnt_d = '0; tag_d = '0; clen_d = '0; left_d = '0;
			seen_d = 1'b0; fid_d = '0; chan_d = '0; rate_d = '0; blk_d = '0;
			bps_d = '0; acc_d = '0; sbi_d = '0; cur_d = '0;
		end
	end

	// State registers advance on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR; fcnt_q <= '0; tag_q <= '0; clen_q <= '0; left_q <= '0;
			seen_q <= 1'b0; fid_q <= '0; chan_q <= '0; rate_q <= '0; blk_q <= '0;
			bps_q <= '0; acc_q <= '0; sbi_q <= '0; cur_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d; fcnt_q <= fcnt_d; tag_q <= tag_d; clen_q <= clen_d;
			left_q <= left_d; seen_q <= seen_d; fid_q <= fid_d; chan_q <= chan_d;
			rate_q <= rate_d; blk_q <= blk_d; bps_q <= bps_d; acc_q <= acc_d;
			sbi_q <= sbi_d; cur_q <= cur_d;
		end
	end

`ifndef SYNTHESIS
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_last |=> phase_q == PH_HDR && !seen_q)
		else $error("phase not reset after last byte");
	a_samples_need_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SAMPLES |-> seen_q && blk_q != '0 && chan_q != '0)
		else $error("sample phase without a valid format");
	a_sbi_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SAMPLES |-> sbi_q < nb)
		else $error("sample byte index out of range");
`endif

endmodule

### sv/rwsp_outbuf.sv
// Output register with a skid stage for the parser results.
// Depends on rwsp_pkg for the result struct.
module rwsp_outbuf
	import rwsp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_data
);

	logic out_v_q, sk_v_q;
	res_t out_d_q, sk_d_q;
	logic pop;

	assign pop       = out_v_q && !out_stall;
	assign full      = sk_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || pop) begin
			out_v_q <= sk_v_q || push;
			sk_v_q  <= 1'b0;
		end else if (push) begin
			sk_v_q <= 1'b1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_d_q <= sk_v_q ? sk_d_q : push_data;
		end else if (push) begin
			sk_d_q <= push_data;
		end
	end

endmodule

### sv/riff_wave_stream_parser.sv
// Top level of the RIFF/WAVE stream parser: byte input, one result channel.
// Depends on rwsp_pkg, rwsp_core and rwsp_outbuf.
//
//  Channel | Signals                                   | Direction
//  input   | in_valid, in_stall, in_byte, in_last      | bytes of the file in
//  output  | out_valid, out_stall, kind .. is_float    | samples, done, error out
//
// One byte is taken per cycle unless in_stall; its result, if any, is registered.
// The chunk walker is a single register stage, so back to back bytes run at full rate.
// A skid register holds one result while the output is stalled; input stalls
// only once both output and skid registers are full.
// Reset clears all parser state; a byte flagged last does the same.
module riff_wave_stream_parser
	import rwsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [31:0] sample_value,
	output logic [15:0]        channel_index,
	output logic               frame_last,
	output logic [2:0]         error_code,
	output logic [31:0]        rate_out,
	output logic [15:0]        channels_out,
	output logic [15:0]        depth_out,
	output logic               is_float
);

	logic fire, res_valid, full;
	res_t res, out_data;

	assign in_stall = full;
	assign fire     = in_valid && !full;

	// Chunk walker and sample assembly.
	rwsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register and skid stage.
	rwsp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && res_valid),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign kind          = out_data.kind;
	assign sample_value  = out_data.sample_value;
	assign channel_index = out_data.channel_index;
	assign frame_last    = out_data.frame_last;
	assign error_code    = out_data.error_code;
	assign rate_out      = out_data.rate_out;
	assign channels_out  = out_data.channels_out;
	assign depth_out     = out_data.depth_out;
	assign is_float      = out_data.is_float;

endmodule

### tb/riff_wave_stream_parser_tb.sv
// Testbench for the RIFF/WAVE stream parser: builds WAV files byte by byte and checks results.
// It predicts every result with its own model of the parser and compares whole results.
// Depends on rwsp_pkg and riff_wave_stream_parser.
module riff_wave_stream_parser_tb;
	import rwsp_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_BYTES   = 200;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         in_byte = 8'h00;
	logic               in_last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         kind;
	logic signed [31:0] sample_value;
	logic [15:0]        channel_index;
	logic               frame_last;
	logic [2:0]         error_code;
	logic [31:0]        rate_out;
	logic [15:0]        channels_out;
	logic [15:0]        depth_out;
	logic               is_float;

	riff_wave_stream_parser uut (.*);

	// Clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Shared bookkeeping.
	res_t       pending_results[$];
	logic [7:0] file_bytes[$];
	int         data_hdr_end;
	bit         idling_on = 1'b1;
	bit         hold_req = 1'b0;
	int         hold_left = 0;
	int         errors = 0;
	int         bytes_sent = 0;
	int         files_sent = 0;
	int         n_samples = 0;
	int         n_done = 0;
	int         n_fail = 0;
	int         quiet_cycles = 0;

	// Parser state as predicted by the testbench.
	phase_t      ph;
	logic [4:0]  fcount;
	logic [31:0] tag_reg, chunk_len, remaining, rate_val, accum;
	logic        fmt_seen;
	logic [15:0] fmt_code, num_ch, blk_align, depth;
	logic [2:0]  acc_idx;
	logic [15:0] chan;

	function automatic void parser_reset();
		ph = PH_HDR; fcount = '0; tag_reg = '0; chunk_len = '0; remaining = '0;
		fmt_seen = 1'b0; fmt_code = '0; num_ch = '0; rate_val = '0; blk_align = '0;
		depth = '0; accum = '0; acc_idx = '0; chan = '0;
	endfunction

	function automatic void push_result(kind_t k, logic [31:0] v, logic [15:0] ch, logic fl,
			err_t e, logic with_fmt);
		res_t r;
		r = '0;
		r.kind = k;
		r.sample_value = v;
		r.channel_index = ch;
		r.frame_last = fl;
		r.error_code = e;
		if (with_fmt) begin
			r.rate_out = rate_val;
			r.channels_out = num_ch;
			r.depth_out = depth;
			r.is_float = (fmt_code == FMT_FLT);
		end
		pending_results.push_back(r);
	endfunction

	function automatic void push_error(err_t e);
		ph = PH_IDLE;
		push_result(KIND_ERROR, '0, '0, 1'b0, e, 1'b0);
	endfunction

	// Format checks at the data header, in their fixed order.
	function automatic void begin_data();
		if (fmt_code != FMT_PCM && fmt_code != FMT_FLT) push_error(ERR_FORMAT);
		else if (fmt_code == FMT_FLT && depth != 16'd32) push_error(ERR_FLT_DEPTH);
		else if (fmt_code == FMT_PCM && (depth == 0 || depth[2:0] != 0 || depth > 16'd32))
			push_error(ERR_FORMAT);
		else if (num_ch == 0 || blk_align == 0) push_error(ERR_FORMAT);
		else begin
			remaining = chunk_len / blk_align;
			chan = '0; accum = '0; acc_idx = '0;
			ph = (remaining == 0) ? PH_IDLE : PH_SAMPLES;
			push_result(KIND_DONE, '0, '0, 1'b0, ERR_NONE, 1'b1);
		end
	endfunction

	function automatic void begin_chunk();
		fcount = '0;
		remaining = chunk_len;
		if (tag_reg == TAG_FMT) begin
			fmt_seen = 1'b1;
			fmt_code = '0; num_ch = '0; rate_val = '0; blk_align = '0; depth = '0;
			ph = (chunk_len == 0) ? PH_ID : PH_FMT;
		end else if (tag_reg == TAG_DATA && fmt_seen) begin
			begin_data();
		end else begin
			ph = (chunk_len == 0) ? PH_ID : PH_SKIP;
		end
	endfunction

	function automatic void take_fmt(logic [7:0] b);
		int k;
		int sh;
		k = fcount;
		sh = (k % 2) * 8;
		if (k < 16) begin
			if (k < 2) fmt_code |= 16'(b) << sh;
			else if (k < 4) num_ch |= 16'(b) << sh;
			else if (k < 8) rate_val |= 32'(b) << ((k - 4) * 8);
			else if (k >= 12 && k < 14) blk_align |= 16'(b) << sh;
			else if (k >= 14) depth |= 16'(b) << sh;
			fcount = fcount + 5'd1;
		end
	endfunction

	function automatic void take_sample(logic [7:0] b);
		int nb;
		logic [31:0] v;
		logic fl;
		nb = depth[5:3];
		if (nb == 0 || nb > 4) begin
			ph = PH_IDLE;
			return;
		end
		accum |= 32'(b) << (acc_idx * 8);
		acc_idx = acc_idx + 3'd1;
		if (acc_idx < nb) return;
		v = accum;
		// PCM narrower than 32 bits is sign-extended; float bits pass untouched.
		if (fmt_code != FMT_FLT && nb < 4 && v[nb * 8 - 1]) v |= 32'hFFFF_FFFF << (nb * 8);
		fl = ({1'b0, chan} + 17'd1) >= {1'b0, num_ch};
		push_result(KIND_SAMPLE, v, chan, fl, ERR_NONE, 1'b0);
		accum = '0;
		acc_idx = '0;
		if (fl) begin
			chan = '0;
			remaining = remaining - 32'd1;
			if (remaining == 0) ph = PH_IDLE;
		end else begin
			chan = chan + 16'd1;
		end
	endfunction

	// Advance the predicted parser by one accepted byte.
	function automatic void predict_byte(logic [7:0] b, logic last);
		if (last && ph < PH_SAMPLES) begin
			push_error(ERR_SHORT);
		end else begin
			case (ph)
				PH_HDR, PH_BADHDR: begin
					tag_reg = {b, tag_reg[31:8]};
					if (fcount == 3 && tag_reg != TAG_RIFF) ph = PH_BADHDR;
					if (fcount == 11) begin
						if (ph == PH_BADHDR || tag_reg != TAG_WAVE) push_error(ERR_HEADER);
						else begin
							ph = PH_ID;
							fcount = '0;
						end
					end else begin
						fcount = fcount + 5'd1;
					end
				end
				PH_ID: begin
					tag_reg = {b, tag_reg[31:8]};
					fcount = fcount + 5'd1;
					if (fcount >= 4) begin
						ph = PH_SIZE;
						fcount = '0;
					end
				end
				PH_SIZE: begin
					chunk_len = {b, chunk_len[31:8]};
					fcount = fcount + 5'd1;
					if (fcount >= 4) begin_chunk();
				end
				PH_FMT, PH_SKIP: begin
					if (ph == PH_FMT) take_fmt(b);
					remaining = remaining - 32'd1;
					if (remaining == 0) begin
						ph = chunk_len[0] ? PH_PAD : PH_ID;
						fcount = '0;
					end
				end
				PH_PAD: begin
					ph = PH_ID;
					fcount = '0;
				end
				PH_SAMPLES: take_sample(b);
				default: ;
			endcase
		end
		if (last) parser_reset();
	endfunction

	// Send one item and predict its result once it is accepted.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idling_on && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (in_stall);
		predict_byte(b, last);
		bytes_sent++;
	endtask

	// Send the built file, ending it early at cut bytes when cut is positive and below its size.
	task automatic send_file(input int cut);
		int n;
		n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
		for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
		files_sent++;
	endtask

	function automatic void put8(logic [7:0] b);
		file_bytes.push_back(b);
	endfunction

	function automatic void put32(logic [31:0] w);
		for (int i = 0; i < 4; i++) put8(w[i * 8 +: 8]);
	endfunction

	// Sample bytes lean on the sign boundaries half of the time.
	function automatic logic [7:0] data_byte();
		logic [7:0] edges[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
		return $urandom_range(1) ? edges[$urandom_range(3)] : 8'($urandom);
	endfunction

	// Build a WAV file: optional junk chunk, optional early data chunk, fmt, data, tail.
	function automatic void build_wav(logic [15:0] fid, logic [15:0] ch, logic [15:0] dep,
			logic [15:0] blk, int frames, int extra, int fmt_len, int junk_len,
			bit data_first, int tail);
		logic [7:0] fields[16];
		int dlen;
		file_bytes.delete();
		put32(TAG_RIFF);
		put32($urandom);
		put32(TAG_WAVE);
		if (junk_len >= 0) begin
			put32(32'h4B4E_554A);
			put32(junk_len);
			for (int i = 0; i < junk_len + junk_len % 2; i++) put8(8'($urandom));
		end
		if (data_first) begin
			put32(TAG_DATA);
			put32(3);
			for (int i = 0; i < 4; i++) put8(8'($urandom));
		end
		{fields[1], fields[0]} = fid;
		{fields[3], fields[2]} = ch;
		{fields[7], fields[6], fields[5], fields[4]} = $urandom;
		{fields[11], fields[10], fields[9], fields[8]} = $urandom;
		{fields[13], fields[12]} = blk;
		{fields[15], fields[14]} = dep;
		put32(TAG_FMT);
		put32(fmt_len);
		for (int i = 0; i < fmt_len + fmt_len % 2; i++) put8(i < 16 ? fields[i] : 8'($urandom));
		dlen = frames * blk + extra;
		put32(TAG_DATA);
		put32(dlen);
		data_hdr_end = file_bytes.size();
		for (int i = 0; i < dlen + tail; i++) put8(data_byte());
	endfunction

	// A valid mixed-format file with small random content.
	function automatic void build_random_wav();
		logic [15:0] ch;
		logic [15:0] dep;
		logic [15:0] fid;
		ch = 16'($urandom_range(4, 1));
		if ($urandom_range(3) == 0) begin
			fid = FMT_FLT;
			dep = 16'd32;
		end else begin
			fid = FMT_PCM;
			dep = 16'd8 * 16'($urandom_range(4, 1));
		end
		build_wav(fid, ch, dep, (ch * dep) >> 3, $urandom_range(10, 1),
			$urandom_range(2) == 0 ? $urandom_range(5) : 0,
			$urandom_range(3) == 0 ? 18 : 16,
			$urandom_range(2) == 0 ? $urandom_range(5) : -1,
			$urandom_range(4) == 0, $urandom_range(3));
	endfunction

	// Header tags, early ends and trailing bytes after an error.
	task automatic test_headers();
		build_wav(FMT_PCM, 1, 8, 1, 2, 0, 16, -1, 0, 0);
		file_bytes[0] = 8'h58;
		send_file(0);
		build_wav(FMT_PCM, 1, 8, 1, 2, 0, 16, -1, 0, 0);
		file_bytes[9] = 8'h00;
		send_file(0);
		build_wav(FMT_PCM, 1, 8, 1, 2, 0, 16, -1, 0, 0);
		send_file(6);
		build_wav(FMT_PCM, 2, 16, 4, 2, 0, 16, -1, 0, 0);
		send_file(data_hdr_end);
	endtask

	// Every sample format, and each format check at the data header.
	task automatic test_formats();
		send_file_of(FMT_PCM, 1, 8, 1);
		send_file_of(FMT_PCM, 2, 16, 4);
		send_file_of(FMT_PCM, 3, 24, 9);
		send_file_of(FMT_PCM, 2, 32, 8);
		send_file_of(FMT_FLT, 2, 32, 8);
		send_file_of(16'h0002, 1, 16, 2);
		send_file_of(16'hFFFF, 1, 16, 2);
		send_file_of(FMT_FLT, 1, 64, 8);
		send_file_of(FMT_PCM, 1, 12, 2);
		send_file_of(FMT_PCM, 1, 0, 2);
		send_file_of(FMT_PCM, 1, 40, 5);
		send_file_of(FMT_PCM, 0, 16, 2);
		send_file_of(FMT_PCM, 1, 16, 0);
		send_file_of(FMT_PCM, 16'hFFFF, 8, 1);
	endtask

	task automatic send_file_of(logic [15:0] fid, logic [15:0] ch, logic [15:0] dep,
			logic [15:0] blk);
		build_wav(fid, ch, dep, blk, 2, 0, 16, -1, 0, 1);
		send_file(0);
	endtask

	// Chunk walking: pads, data before fmt, short and empty fmt, repeated fmt, truncation.
	task automatic test_layout();
		logic [7:0] second_fmt[34] = '{8'h66, 8'h6D, 8'h74, 8'h20, 8'd16, 8'd0, 8'd0, 8'd0,
			8'd1, 8'd0, 8'd1, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0,
			8'd1, 8'd0, 8'd8, 8'd0, 8'h64, 8'h61, 8'h74, 8'h61, 8'd2, 8'd0, 8'd0, 8'd0,
			8'h80, 8'h7F};
		build_wav(FMT_PCM, 1, 16, 2, 3, 1, 16, 3, 1, 2);
		send_file(0);
		build_wav(FMT_PCM, 1, 16, 2, 3, 0, 14, -1, 0, 0);
		send_file(0);
		build_wav(FMT_PCM, 1, 16, 2, 3, 0, 0, -1, 0, 0);
		send_file(0);
		build_wav(FMT_PCM, 2, 8, 2, 3, 0, 17, -1, 0, 0);
		send_file(0);
		build_wav(FMT_PCM, 2, 16, 4, 0, 3, 16, -1, 0, 2);
		send_file(0);
		build_wav(FMT_PCM, 2, 16, 4, 5, 0, 16, -1, 0, 0);
		send_file(data_hdr_end + 7);
		// A second fmt chunk replaces the first one.
		build_wav(FMT_FLT, 1, 64, 8, 0, 0, 16, -1, 0, 0);
		repeat (8) void'(file_bytes.pop_back());
		foreach (second_fmt[i]) put8(second_fmt[i]);
		send_file(0);
	endtask

	// Mostly well-formed files, some corrupted, cut short or pure noise.
	task automatic test_random();
		int target;
		int pick;
		target = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 15) idling_on = 1'b0;
			else idling_on = 1'b1;
			build_random_wav();
			if (pick < 70) begin
				send_file(0);
			end else if (pick < 82) begin
				file_bytes[$urandom_range(file_bytes.size() - 1)] ^= 8'($urandom_range(255, 1));
				send_file(0);
			end else if (pick < 92) begin
				send_file($urandom_range(file_bytes.size(), 1));
			end else begin
				file_bytes.delete();
				repeat ($urandom_range(20, 1)) put8(8'($urandom));
				send_file(0);
			end
		end
		idling_on = 1'b1;
	endtask

	// The receiver holds off long enough for the parser to stall its input.
	task automatic test_backpressure();
		hold_req = 1'b1;
		build_wav(FMT_PCM, 1, 8, 1, 40, 0, 16, -1, 0, 0);
		send_file(0);
	endtask

	// Receiver: random stalls, or a long counted hold-off on request.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idling_on && ($urandom_range(99) < 18);
		end
	end

	// Compare each accepted result with the oldest expected one.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, sample_value, channel_index, frame_last, error_code, rate_out,
				channels_out, depth_out, is_float};
			case (kind_t'(kind))
				KIND_SAMPLE: n_samples++;
				KIND_DONE:   n_done++;
				default:     n_fail++;
			endcase
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: %p", $time, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t mismatch: expected %p, actual %p", $time, want, got);
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else if (arst_n) quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no progress, %0d results outstanding", $time,
				pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		parser_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_headers();
		test_formats();
		test_layout();
		test_backpressure();
		test_random();
		in_valid <= 1'b0;
		in_last <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes in %0d files; checked %0d samples, %0d format results,",
			bytes_sent, files_sent, n_samples, n_done);
		$display("and %0d error results, including a long output hold-off.", n_fail);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
